// ===== design/dtc_pkg.sv =====
package dtc_pkg;

  // Cache geometry
  localparam int SLOTS        = 16;
  localparam int SECTOR_SHIFT = 8;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int TRACK_W      = 24;
  localparam int STAMP_W      = 32;
  localparam int BLOCK_W      = 32;
  localparam int STATUS_W     = 3;
  localparam int OUT_SLOT_W   = 4;
  localparam int COUNT_W      = 9;

  // Sector count arithmetic
  localparam int START_W = TRACK_W + SECTOR_SHIFT;
  localparam int CMP_W   = (START_W > BLOCK_W) ? START_W : BLOCK_W;
  localparam int SEC_W   = SECTOR_SHIFT + 1;
  localparam logic [SEC_W-1:0] SEC_CAP = SEC_W'(1) << SECTOR_SHIFT;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FILL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EVICT     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LOAD_FAIL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SAVE_FAIL = 3'd4;

  // Word carried down the cell chain, one cell per cycle
  typedef struct packed {
    logic               go;
    logic               hit;
    logic [SLOT_W-1:0]  hit_idx;
    logic               empty_found;
    logic [SLOT_W-1:0]  empty_idx;
    logic               min_any;
    logic [STAMP_W-1:0] min_stamp;
    logic [SLOT_W-1:0]  min_idx;
    logic [TRACK_W-1:0] min_track;
  } scan_t;

  // Broadcast update from the controller to every cell
  typedef struct packed {
    logic               clr_stamps;
    logic               wr;
    logic [SLOT_W-1:0]  idx;
    logic               stamp_en;
    logic [STAMP_W-1:0] stamp;
    logic               valid_en;
    logic               valid;
    logic               track_en;
    logic [TRACK_W-1:0] track;
  } upd_t;

endpackage

// ===== design/disk_track_cache_lru.sv =====
// A word accepted on start is launched by launch_r into the cell chain, and its result is
// registered onto out_strobe and the result word once the search word leaves the last cell.
// One word is in flight at a time (busy stays high until then); the search word walks the
// cell chain one slot per cycle, and start may be taken again in the cycle out_strobe is high.
// Reset (rst_n low, synchronous): slots empty, stamps and serial zero, total_blocks one.
// Results cannot be stalled by the receiver.
module disk_track_cache_lru import dtc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [BLOCK_W-1:0]    cfg_wdata,
  input  logic                  start,
  output logic                  busy,
  input  logic [BLOCK_W-1:0]    in_block_number,
  input  logic                  in_save_ok,
  input  logic                  in_load_ok,
  output logic                  out_strobe,
  output logic [STATUS_W-1:0]   out_status,
  output logic [OUT_SLOT_W-1:0] out_slot,
  output logic [TRACK_W-1:0]    out_track_number,
  output logic                  out_victim_valid,
  output logic [TRACK_W-1:0]    out_victim_track,
  output logic [COUNT_W-1:0]    out_sector_count
);

  logic [BLOCK_W-1:0]  total_blocks_r;
  logic                busy_r;
  logic                launch_r;
  logic [STAMP_W-1:0]  serial_r;
  logic [STAMP_W-1:0]  serial_nxt;
  logic [TRACK_W-1:0]  track_r;
  logic                save_ok_r;
  logic                load_ok_r;
  logic [SEC_W-1:0]    secs_r;
  logic [SEC_W-1:0]    secs_nxt;
  logic                accept;
  scan_t               chain [SLOTS+1];
  scan_t               fin;
  upd_t                upd;

  logic                  out_strobe_r;
  logic [STATUS_W-1:0]   status_r,   status_nxt;
  logic [OUT_SLOT_W-1:0] slot_r,     slot_nxt;
  logic                  vvalid_r,   vvalid_nxt;
  logic [TRACK_W-1:0]    vtrack_r,   vtrack_nxt;
  logic [COUNT_W-1:0]    count_r,    count_nxt;

  assign accept     = start && !busy_r;
  assign serial_nxt = serial_r + STAMP_W'(1);
  assign fin        = chain[SLOTS];

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_blocks_r <= BLOCK_W'(1);
    end else if (cfg_we) begin
      total_blocks_r <= cfg_wdata;
    end
  end

  // Control: busy flag, launch pulse, access serial
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      launch_r <= 1'b0;
      serial_r <= '0;
    end else begin
      launch_r <= accept;
      if (accept) begin
        busy_r   <= 1'b1;
        serial_r <= serial_nxt;
      end else if (fin.go) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Request word capture
  always_ff @(posedge clk) begin
    if (accept) begin
      track_r   <= TRACK_W'(in_block_number >> SECTOR_SHIFT);
      save_ok_r <= in_save_ok;
      load_ok_r <= in_load_ok;
    end
  end

  // Sectors in the requested track, ready long before the scan ends
  always_comb begin
    logic [CMP_W-1:0] start_blk;
    logic [CMP_W-1:0] total;
    logic [CMP_W-1:0] diff;
    start_blk = CMP_W'({track_r, {SECTOR_SHIFT{1'b0}}});
    total     = CMP_W'(total_blocks_r);
    diff      = total - start_blk;
    if (start_blk >= total) begin
      secs_nxt = '0;
    end else if (diff > CMP_W'(SEC_CAP)) begin
      secs_nxt = SEC_CAP;
    end else begin
      secs_nxt = diff[SEC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (launch_r) begin
      secs_r <= secs_nxt;
    end
  end

  // Cell chain
  always_comb begin
    chain[0]    = '0;
    chain[0].go = launch_r;
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    dtc_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (SLOT_W'(i)),
      .query_track (track_r),
      .scan_in     (chain[i]),
      .scan_out    (chain[i+1]),
      .upd         (upd)
    );
  end

  // Decision once the search word leaves the last cell
  always_comb begin
    logic              evict;
    logic [SLOT_W-1:0] target;
    upd            = '0;
    upd.clr_stamps = accept && (serial_nxt == '0);
    upd.stamp      = serial_r;
    upd.track      = track_r;
    evict          = !fin.empty_found;
    target         = fin.empty_found ? fin.empty_idx : fin.min_idx;
    status_nxt     = ST_HIT;
    slot_nxt       = '0;
    vvalid_nxt     = 1'b0;
    vtrack_nxt     = '0;
    count_nxt      = '0;
    if (fin.hit) begin
      slot_nxt     = OUT_SLOT_W'(fin.hit_idx);
      upd.wr       = fin.go;
      upd.idx      = fin.hit_idx;
      upd.stamp_en = 1'b1;
    end else begin
      slot_nxt   = OUT_SLOT_W'(target);
      vvalid_nxt = evict;
      vtrack_nxt = evict ? fin.min_track : '0;
      upd.idx    = target;
      priority if (evict && !save_ok_r) begin
        status_nxt = ST_SAVE_FAIL;
      end else if (load_ok_r && (secs_r != '0)) begin
        status_nxt   = evict ? ST_EVICT : ST_FILL;
        count_nxt    = COUNT_W'(secs_r);
        upd.wr       = fin.go;
        upd.stamp_en = 1'b1;
        upd.valid_en = 1'b1;
        upd.valid    = 1'b1;
        upd.track_en = 1'b1;
      end else begin
        // failed load leaves the target slot empty
        status_nxt   = ST_LOAD_FAIL;
        upd.wr       = fin.go;
        upd.valid_en = 1'b1;
        upd.valid    = 1'b0;
      end
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= fin.go;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.go) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      vvalid_r <= vvalid_nxt;
      vtrack_r <= vtrack_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.go) begin
      out_track_number <= track_r;
    end
  end

  assign busy             = busy_r;
  assign out_strobe       = out_strobe_r;
  assign out_status       = status_r;
  assign out_slot         = slot_r;
  assign out_victim_valid = vvalid_r;
  assign out_victim_track = vtrack_r;
  assign out_sector_count = count_r;

  // Checks
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> !busy_r)
    else $error("result strobe while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && launch_r)
    else $error("accepted word did not start a scan");

  a_scan_owned: assert property (@(posedge clk) disable iff (!rst_n)
    fin.go |-> busy_r)
    else $error("search word left the chain with no request in flight");

  a_hit_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && (status_r == ST_HIT)) |-> !vvalid_r && (count_r == '0))
    else $error("hit reported a victim or a sector count");

  a_count_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && (count_r != '0)) |-> ((status_r == ST_FILL) || (status_r == ST_EVICT)))
    else $error("sector count without a fill");

endmodule

// ===== design/dtc_cell.sv =====
module dtc_cell import dtc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SLOT_W-1:0]  cell_idx,
  input  logic [TRACK_W-1:0] query_track,
  input  scan_t              scan_in,
  output scan_t              scan_out,
  input  upd_t               upd
);

  logic               valid_r;
  logic [TRACK_W-1:0] track_r;
  logic [STAMP_W-1:0] stamp_r;
  scan_t              scan_r;
  scan_t              scan_nxt;

  // Fold this slot into the travelling search word
  always_comb begin
    scan_nxt = scan_in;
    if (scan_in.go) begin
      if (!scan_in.hit && valid_r && (track_r == query_track)) begin
        scan_nxt.hit     = 1'b1;
        scan_nxt.hit_idx = cell_idx;
      end
      if (!scan_in.empty_found && !valid_r) begin
        scan_nxt.empty_found = 1'b1;
        scan_nxt.empty_idx   = cell_idx;
      end
      // strict less-than keeps the lowest index on a tie
      if (!scan_in.min_any || (stamp_r < scan_in.min_stamp)) begin
        scan_nxt.min_any   = 1'b1;
        scan_nxt.min_stamp = stamp_r;
        scan_nxt.min_idx   = cell_idx;
        scan_nxt.min_track = track_r;
      end
    end
  end

  // Hand the word to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  assign scan_out = scan_r;

  // Slot state: valid and stamp reset, track left undefined
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      stamp_r <= '0;
    end else begin
      if (upd.clr_stamps) begin
        stamp_r <= '0;
      end
      if (upd.wr && (upd.idx == cell_idx)) begin
        if (upd.stamp_en) begin
          stamp_r <= upd.stamp;
        end
        if (upd.valid_en) begin
          valid_r <= upd.valid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.wr && (upd.idx == cell_idx) && upd.track_en) begin
      track_r <= upd.track;
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import dtc_pkg::*;

  localparam int GUARD_CYCLES = 400000;
  localparam int LATENCY      = SLOTS + 1;
  localparam int POOL_SIZE    = 24;
  localparam int SECTORS      = 1 << SECTOR_SHIFT;

  // One request word and one result word
  typedef struct packed {
    logic [BLOCK_W-1:0] block;
    logic               save_ok;
    logic               load_ok;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [TRACK_W-1:0]    track;
    logic                  victim_valid;
    logic [TRACK_W-1:0]    victim_track;
    logic [COUNT_W-1:0]    sector_count;
  } outcome_t;

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  cfg_we          = 1'b0;
  logic [BLOCK_W-1:0]    cfg_wdata       = '0;
  logic                  start           = 1'b0;
  logic                  busy;
  logic [BLOCK_W-1:0]    in_block_number = '0;
  logic                  in_save_ok      = 1'b0;
  logic                  in_load_ok      = 1'b0;
  logic                  out_strobe;
  logic [STATUS_W-1:0]   out_status;
  logic [OUT_SLOT_W-1:0] out_slot;
  logic [TRACK_W-1:0]    out_track_number;
  logic                  out_victim_valid;
  logic [TRACK_W-1:0]    out_victim_track;
  logic [COUNT_W-1:0]    out_sector_count;

  request_t    request_q[$];
  outcome_t    outcome_q[$];
  request_t    held_request;
  outcome_t    oldest;
  int          gap_pct     = 0;
  int          error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned track_pool[POOL_SIZE];

  // Shadow copy of the track cache
  logic [TRACK_W-1:0] cache_track[SLOTS];
  logic               cache_valid[SLOTS];
  logic [STAMP_W-1:0] cache_stamp[SLOTS];
  logic [STAMP_W-1:0] cache_serial;
  logic [BLOCK_W-1:0] cache_total_blocks;

  disk_track_cache_lru i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_block_number  (in_block_number),
    .in_save_ok       (in_save_ok),
    .in_load_ok       (in_load_ok),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_track_number (out_track_number),
    .out_victim_valid (out_victim_valid),
    .out_victim_track (out_victim_track),
    .out_sector_count (out_sector_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Look up one block, update the shadow cache, return the outcome it should give
  function automatic outcome_t access_cache(request_t req);
    logic [TRACK_W-1:0] trk;
    int                 target;
    logic               evict;
    longint unsigned    first_block;
    longint unsigned    secs;
    outcome_t           res;
    trk          = TRACK_W'(req.block >> SECTOR_SHIFT);
    res          = '0;
    res.track    = trk;
    target       = -1;
    evict        = 1'b0;
    cache_serial = cache_serial + 1'b1;
    // serial wrap clears every stamp
    if (cache_serial == '0)
      for (int i = 0; i < SLOTS; i++) cache_stamp[i] = '0;
    for (int i = 0; i < SLOTS; i++)
      if (target < 0 && cache_valid[i] && cache_track[i] == trk) target = i;
    if (target >= 0) begin
      cache_stamp[target] = cache_serial;
      res.status          = ST_HIT;
      res.slot            = OUT_SLOT_W'(target);
      return res;
    end
    for (int i = 0; i < SLOTS; i++)
      if (target < 0 && !cache_valid[i]) target = i;
    // no empty slot: oldest stamp goes, lowest index on a tie
    if (target < 0) begin
      target = 0;
      for (int i = 1; i < SLOTS; i++)
        if (cache_stamp[i] < cache_stamp[target]) target = i;
      evict            = 1'b1;
      res.victim_valid = 1'b1;
      res.victim_track = cache_track[target];
    end
    res.slot = OUT_SLOT_W'(target);
    if (evict && !req.save_ok) begin
      res.status = ST_SAVE_FAIL;
      return res;
    end
    cache_valid[target] = 1'b0;
    first_block = 64'(trk);
    first_block = first_block << SECTOR_SHIFT;
    secs = (first_block >= 64'(cache_total_blocks)) ? 64'd0
                                                    : 64'(cache_total_blocks) - first_block;
    if (secs > 64'(SECTORS)) secs = 64'(SECTORS);
    if (req.load_ok && secs != 0) begin
      cache_valid[target] = 1'b1;
      cache_track[target] = trk;
      cache_stamp[target] = cache_serial;
      res.status          = evict ? ST_EVICT : ST_FILL;
      res.sector_count    = COUNT_W'(secs);
    end else begin
      res.status = ST_LOAD_FAIL;
    end
    return res;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Tracks spread from zero to just past the end of the image, both ends always in, plus a few anywhere
  function automatic void fill_pool(logic [BLOCK_W-1:0] blocks);
    int unsigned top;
    top = blocks >> SECTOR_SHIFT;
    if (top < (1 << TRACK_W) - 1) top = top + 1;
    for (int i = 0; i < POOL_SIZE; i++)
      track_pool[i] = (i < 20) ? $urandom_range(top, 0) : ($urandom & ((1 << TRACK_W) - 1));
    track_pool[0] = 0;
    track_pool[1] = top;
  endfunction

  // Mostly pooled tracks so hits and evictions are common
  function automatic request_t random_request();
    request_t    r;
    int unsigned trk;
    r.save_ok = ($urandom_range(99) < 85);
    r.load_ok = ($urandom_range(99) < 88);
    if ($urandom_range(99) < 85) begin
      trk     = track_pool[$urandom_range(POOL_SIZE - 1)];
      r.block = (BLOCK_W'(trk) << SECTOR_SHIFT) | ($urandom & (SECTORS - 1));
    end else begin
      r.block = $urandom;
    end
    return r;
  endfunction

  task automatic add_request(logic [BLOCK_W-1:0] block, logic save_ok, logic load_ok);
    request_t r;
    r.block   = block;
    r.save_ok = save_ok;
    r.load_ok = load_ok;
    request_q.insert(request_q.size(), r);
  endtask

  task automatic write_total_blocks(logic [BLOCK_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we             <= 1'b0;
    cache_total_blocks =  value;
    @(negedge clk);
  endtask

  // Wait until every word is sent and every result has come back
  task automatic drain();
    do @(negedge clk); while (request_q.size() != 0 || start || outcome_q.size() != 0);
  endtask

  task automatic run_phase(logic [BLOCK_W-1:0] blocks, int idle, int count);
    write_total_blocks(blocks);
    gap_pct = idle;
    fill_pool(blocks);
    repeat (count) request_q.insert(request_q.size(), random_request());
    drain();
  endtask

  // Driver: present the next word once the last one has gone
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) outcome_q.insert(outcome_q.size(), access_cache(held_request));
      if (!start || !busy) begin
        if (request_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          held_request    = request_q.pop_front();
          start           <= 1'b1;
          in_block_number <= held_request.block;
          in_save_ok      <= held_request.save_ok;
          in_load_ok      <= held_request.load_ok;
        end else begin
          start           <= 1'b0;
          in_block_number <= $urandom;
          in_save_ok      <= 1'($urandom_range(1));
          in_load_ok      <= 1'($urandom_range(1));
        end
      end
    end
  end

  // Monitor: every strobed result against the oldest outstanding outcome
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (outcome_q.size() == 0) begin
        $error("unexpected result word for track %0h", out_track_number);
        error_count++;
      end else begin
        oldest = outcome_q.pop_front();
        check_field("status", 64'(oldest.status), 64'(out_status));
        check_field("slot", 64'(oldest.slot), 64'(out_slot));
        check_field("track_number", 64'(oldest.track), 64'(out_track_number));
        check_field("victim_valid", 64'(oldest.victim_valid), 64'(out_victim_valid));
        check_field("victim_track", 64'(oldest.victim_track), 64'(out_victim_track));
        check_field("sector_count", 64'(oldest.sector_count), 64'(out_sector_count));
      end
    end
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == GUARD_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      cache_track[i] = '0;
      cache_valid[i] = 1'b0;
      cache_stamp[i] = '0;
    end
    cache_serial       = '0;
    cache_total_blocks = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: sixteen full tracks and a short seventeenth
    write_total_blocks(16 * SECTORS + 100);
    gap_pct = 26;
    add_request(0, 1'b1, 1'b1);                    // fill, full track
    add_request(SECTORS - 1, 1'b1, 1'b1);          // hit
    add_request(16 * SECTORS + 5, 1'b1, 1'b1);     // fill, short last track
    add_request(17 * SECTORS, 1'b1, 1'b1);         // past the end
    add_request(SECTORS + 7, 1'b1, 1'b0);          // load refused
    for (int t = 1; t <= 14; t++) add_request(t * SECTORS, 1'b1, 1'b1);
    add_request(15 * SECTORS, 1'b0, 1'b1);         // save refused, victim stays
    add_request('1, 1'b1, 1'b1);                   // victim dropped, load past end
    add_request(15 * SECTORS + 255, 1'b1, 1'b1);   // refill the freed slot
    add_request(SECTORS, 1'b0, 1'b0);              // hit ignores both flags
    add_request(3, 1'b1, 1'b1);                    // evict and fill
    drain();

    run_phase('1, 26, 500);
    run_phase($urandom_range(28 * SECTORS, 20 * SECTORS), 69, 450);
    run_phase(1, 0, 100);
    run_phase($urandom_range(32'hFFFF_FFFF, 1), 0, 400);

    repeat (2 * LATENCY) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
